>>> hw/rtl/pulse_period_speed_meter_unit_macros.svh
// Assertion macros for the pulse period speed meter checker.
// Included by files that assert; no other dependencies.
`ifndef PULSE_PERIOD_SPEED_METER_UNIT_MACROS_SVH
`define PULSE_PERIOD_SPEED_METER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PSMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speed meter check failed");

// Next-cycle implication, disabled during reset
`define PSMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speed meter check failed");

`endif

>>> hw/rtl/ppsm_pkg.sv
// Shared types and constants of the pulse period speed meter.
// No dependencies; used by all speed meter modules.
`default_nettype none

package ppsm_pkg;

  // Field widths
  localparam int TS_BITS     = 48;
  localparam int DEB_BITS    = 16;
  localparam int CFG_BITS    = 24;
  localparam int SPEED_BITS  = 10;
  localparam int STATUS_BITS = 2;
  localparam int OUT_BITS    = 16;
  localparam int CADDR_BITS  = 2;

  // Divider width: periods at or above 2^PERIOD_BITS always round to zero
  localparam int PERIOD_BITS = CFG_BITS + 1;
  localparam int CNT_BITS    = $clog2(PERIOD_BITS);

  // Item kinds
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_MOVING     = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_STANDSTILL = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD_PERIOD = 2'd2;

  // Configuration register indexes
  localparam logic [CADDR_BITS-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CADDR_BITS-1:0] CFG_STANDSTILL = 2'd1;
  localparam logic [CADDR_BITS-1:0] CFG_SPEED_K    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DEB_BITS-1:0] DEBOUNCE_RST   = 16'd2000;
  localparam logic [CFG_BITS-1:0] STANDSTILL_RST = 24'd500000;
  localparam logic [CFG_BITS-1:0] SPEED_K_RST    = 24'd1448406;

  localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

  // Query classification from the edge tracker
  typedef struct packed {
    logic                   standstill;
    logic                   period_zero;
    logic                   period_big;
    logic [PERIOD_BITS-1:0] period;
  } ppsm_query_t;

  // Control state of the top level
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_PUSH = 3'b100
  } ppsm_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppsm_edge_track.sv
// Edge time store with debounce, and query classification.
// Depends on ppsm_pkg.
`default_nettype none

module ppsm_edge_track #(
  parameter int TIME_BITS = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              item_acc,
  input  wire logic                              opcode,
  input  wire logic [ppsm_pkg::TS_BITS-1:0]      timestamp_us,
  input  wire logic [ppsm_pkg::DEB_BITS-1:0]     debounce_us,
  input  wire logic [ppsm_pkg::CFG_BITS-1:0]     standstill_us,
  output ppsm_pkg::ppsm_query_t                  qry
);

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] newest_r;
  logic [TIME_BITS-1:0] prev_r;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] period;
  logic                 edge_take;

  // Fit the timestamp to the time base width
  if (TIME_BITS > ppsm_pkg::TS_BITS) begin : g_ext
    assign now = {{(TIME_BITS - ppsm_pkg::TS_BITS){1'b0}}, timestamp_us};
  end else if (TIME_BITS == ppsm_pkg::TS_BITS) begin : g_eq
    assign now = timestamp_us;
  end else begin : g_trunc
    assign now = timestamp_us[TIME_BITS-1:0];
  end

  // Wrapping differences
  assign elapsed = now - newest_r;
  assign period  = newest_r - prev_r;

  assign edge_take = elapsed > {{(TIME_BITS - ppsm_pkg::DEB_BITS){1'b0}}, debounce_us};

  always_comb begin
    qry.standstill  = elapsed >= {{(TIME_BITS - ppsm_pkg::CFG_BITS){1'b0}}, standstill_us};
    qry.period_zero = period == '0;
    qry.period_big  = |period[TIME_BITS-1:ppsm_pkg::PERIOD_BITS];
    qry.period      = period[ppsm_pkg::PERIOD_BITS-1:0];
  end

  // Shift in an accepted edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      prev_r   <= '0;
    end else if (item_acc && opcode == ppsm_pkg::OP_EDGE && edge_take) begin
      prev_r   <= newest_r;
      newest_r <= now;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppsm_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturating result.
// Depends on ppsm_pkg.
`default_nettype none

module ppsm_divider (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [ppsm_pkg::PERIOD_BITS-1:0]     dividend,
  input  wire logic [ppsm_pkg::PERIOD_BITS-1:0]     divisor,
  output logic                                      done,
  output logic [ppsm_pkg::SPEED_BITS-1:0]           speed_kmh
);

  localparam int PB = ppsm_pkg::PERIOD_BITS;
  localparam int CB = ppsm_pkg::CNT_BITS;
  localparam int SB = ppsm_pkg::SPEED_BITS;

  logic [PB-1:0] quo_r;   // dividend bits shift out the top, quotient bits in the bottom
  logic [PB-1:0] rem_r;
  logic [PB-1:0] dsr_r;
  logic [CB-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [PB:0]   partial;
  logic [PB:0]   diff;
  logic          take;

  // One restoring step
  assign partial = {rem_r, quo_r[PB-1]};
  assign diff    = partial - {1'b0, dsr_r};
  assign take    = partial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CB'(PB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[PB-2:0], take};
      rem_r <= take ? diff[PB-1:0] : partial[PB-1:0];
    end
  end

  // Saturate at full scale
  assign done      = done_r;
  assign speed_kmh = (|quo_r[PB-1:SB]) ? ppsm_pkg::SPEED_MAX : quo_r[SB-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/pulse_period_speed_meter_unit.sv
// Pulse period speed meter, top level: config registers, control and output register.
// Depends on ppsm_pkg, ppsm_edge_track and ppsm_divider.
//
// Takes edge and query transactions carrying a microsecond timestamp. An edge
// transaction never produces a result. A query that ends in standstill, a zero
// period or a period too long to round above zero has its result registered as
// pending and then moved into the output register; any other query first runs
// through a bit-serial restoring divider that makes one quotient bit per cycle.
// One item is in work at a time; the next item is taken as soon as the result
// sits in the output register, even if it has not been taken yet. Configuration
// writes land at once and are meant to be done while the block is idle.
`default_nettype none

module pulse_period_speed_meter_unit #(
  parameter int TIME_BITS = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ppsm_pkg::TS_BITS-1:0]        in_tdata,   // [47:0] timestamp_us
  input  wire logic                                in_tuser,   // [0] opcode
  // Result channel
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ppsm_pkg::OUT_BITS-1:0]            out_tdata,  // [9:0] speed_kmh, zero fill
  output logic [ppsm_pkg::STATUS_BITS-1:0]         out_tuser,  // [1:0] speed_status
  // Configuration port
  input  wire logic                                cfg_we,
  input  wire logic [ppsm_pkg::CADDR_BITS-1:0]     cfg_addr,
  input  wire logic [ppsm_pkg::CFG_BITS-1:0]       cfg_wdata
);

  localparam int PB = ppsm_pkg::PERIOD_BITS;
  localparam int SB = ppsm_pkg::SPEED_BITS;

  ppsm_pkg::ppsm_state_t state_r, state_nxt;

  logic [ppsm_pkg::DEB_BITS-1:0]    debounce_r;
  logic [ppsm_pkg::CFG_BITS-1:0]    standstill_r;
  logic [ppsm_pkg::CFG_BITS-1:0]    speed_k_r;
  logic [SB-1:0]                    res_kmh_r;
  logic [ppsm_pkg::STATUS_BITS-1:0] res_status_r;
  logic                             out_valid_r;
  logic [SB-1:0]                    out_kmh_r;
  logic [ppsm_pkg::STATUS_BITS-1:0] out_status_r;
  logic                             in_acc;
  logic                             query_acc;
  logic                             div_start;
  logic                             div_done;
  logic [SB-1:0]                    div_kmh;
  logic [PB-1:0]                    dividend;
  logic                             out_load;
  ppsm_pkg::ppsm_query_t            qry;

  assign in_tready = state_r == ppsm_pkg::S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign query_acc = in_acc && in_tuser == ppsm_pkg::OP_QUERY;
  assign out_load  = state_r == ppsm_pkg::S_PUSH && (!out_valid_r || out_tready);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= ppsm_pkg::DEBOUNCE_RST;
      standstill_r <= ppsm_pkg::STANDSTILL_RST;
      speed_k_r    <= ppsm_pkg::SPEED_K_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ppsm_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[ppsm_pkg::DEB_BITS-1:0];
        ppsm_pkg::CFG_STANDSTILL: standstill_r <= cfg_wdata;
        ppsm_pkg::CFG_SPEED_K:    speed_k_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppsm_edge_track #(
    .TIME_BITS (TIME_BITS)
  ) u_edge (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_acc      (in_acc),
    .opcode        (in_tuser),
    .timestamp_us  (in_tdata),
    .debounce_us   (debounce_r),
    .standstill_us (standstill_r),
    .qry           (qry)
  );

  // Rounded dividend: K + T/2
  assign dividend  = {1'b0, speed_k_r} + {1'b0, qry.period[PB-1:1]};
  assign div_start = query_acc && !qry.standstill && !qry.period_zero && !qry.period_big;

  ppsm_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dividend),
    .divisor   (qry.period),
    .done      (div_done),
    .speed_kmh (div_kmh)
  );

  // Control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppsm_pkg::S_IDLE: begin
        if (query_acc) begin
          state_nxt = div_start ? ppsm_pkg::S_CALC : ppsm_pkg::S_PUSH;
        end
      end
      ppsm_pkg::S_CALC: begin
        if (div_done) begin
          state_nxt = ppsm_pkg::S_PUSH;
        end
      end
      ppsm_pkg::S_PUSH: begin
        if (out_load) begin
          state_nxt = ppsm_pkg::S_IDLE;
        end
      end
      default: state_nxt = ppsm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppsm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (query_acc) begin
      res_kmh_r <= '0;
      if (qry.standstill) begin
        res_status_r <= ppsm_pkg::ST_STANDSTILL;
      end else if (qry.period_zero) begin
        res_status_r <= ppsm_pkg::ST_BAD_PERIOD;
      end else begin
        res_status_r <= ppsm_pkg::ST_MOVING;
      end
    end else if (state_r == ppsm_pkg::S_CALC && div_done) begin
      res_kmh_r <= div_kmh;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kmh_r    <= res_kmh_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ppsm_pkg::OUT_BITS - SB){1'b0}}, out_kmh_r};
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

>>> hw/rtl/ppsm_checker.sv
// Port-level checks of the pulse period speed meter, bound to the top level.
// Depends on ppsm_pkg and pulse_period_speed_meter_unit_macros.svh.
`default_nettype none

`include "pulse_period_speed_meter_unit_macros.svh"

module ppsm_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [ppsm_pkg::TS_BITS-1:0]        in_tdata,
  input wire logic                                in_tuser,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [ppsm_pkg::OUT_BITS-1:0]       out_tdata,
  input wire logic [ppsm_pkg::STATUS_BITS-1:0]    out_tuser,
  input wire logic                                cfg_we,
  input wire logic [ppsm_pkg::CADDR_BITS-1:0]     cfg_addr,
  input wire logic [ppsm_pkg::CFG_BITS-1:0]       cfg_wdata
);

  logic in_acc;
  logic cfg_any;

  assign in_acc  = in_tvalid && in_tready;
  assign cfg_any = cfg_we || (|cfg_addr) || (|cfg_wdata) || (|in_tdata);

  // A stalled result holds still
  `PSMU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Only a moving status carries a nonzero speed
  `PSMU_ASSERT_NOW(a_zero_speed, clk, rst_n,
    out_tvalid && out_tuser != ppsm_pkg::ST_MOVING, out_tdata == '0 || !cfg_any && out_tdata == '0)

  // An edge with an empty output never creates a result
  `PSMU_ASSERT_NEXT(a_edge_silent, clk, rst_n,
    in_acc && in_tuser == ppsm_pkg::OP_EDGE && !out_tvalid, !out_tvalid)

  // A query blocks the input while it is worked on
  `PSMU_ASSERT_NEXT(a_query_busy, clk, rst_n,
    in_acc && in_tuser == ppsm_pkg::OP_QUERY, !in_tready)

endmodule

bind pulse_period_speed_meter_unit ppsm_checker u_ppsm_checker (.*);

`default_nettype wire
